// ----- src/hmtd_pkg.sv -----
// Shared types, constants and CRC function for the humidity/temperature frame decoder.
package hmtd_pkg;

   // Reply layout: two words, each WORD_BYTES data bytes plus one CRC byte
   localparam int WORD_BYTES  = 2;
   localparam int FRAME_BYTES = 2 * (WORD_BYTES + 1);

   // CRC-8, x^8+x^5+x^4+1, no reflection, no final xor
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   // Conversion constants: temp = 17500*raw/2^16 - 4500, hum = 10000*raw/2^16
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;

   // Register map (byte addresses)
   localparam int          CSR_ADDR_W           = 2;
   localparam logic [1:0]  ADDR_HUMIDITY_FIRST  = 2'd0;
   localparam logic        HUMIDITY_FIRST_RESET = 1'b1;

   // Byte position within a reply, one-hot
   typedef enum logic [5:0] {
      POS_W0_HI  = 6'b000001,
      POS_W0_LO  = 6'b000010,
      POS_W0_CRC = 6'b000100,
      POS_W1_HI  = 6'b001000,
      POS_W1_LO  = 6'b010000,
      POS_W1_CRC = 6'b100000
   } pos_type;

   // Frame tracker to converter: completed reply contents
   typedef struct packed {
      logic        done;
      logic [15:0] first_word;
      logic [15:0] second_word;
      logic        first_ok;
      logic        second_ok;
   } frame_type;

   // One byte through the CRC-8 register, MSB first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- src/hmtd_frame.sv -----
// Byte position tracking, running CRC and word capture for one reply.
module hmtd_frame (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        rx_byte,
   input  logic              frame_start,
   output hmtd_pkg::frame_type frame
);
   import hmtd_pkg::*;

   pos_type     pos_ff, pos_in, pos_sel;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] word0_ff, word0_in;
   logic [15:0] word1_ff, word1_in;
   logic        ok0_ff, ok0_in;
   logic        done;
   logic        ok1;

   // start flag forces byte zero
   assign pos_sel = frame_start ? POS_W0_HI : pos_ff;

   // next-state decode per byte position
   always_comb begin
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      word0_in = word0_ff;
      word1_in = word1_ff;
      ok0_in   = ok0_ff;
      done     = 1'b0;
      ok1      = 1'b0;
      unique case (pos_sel)
         POS_W0_HI: begin
            crc_in   = crc8_update(CRC_INIT, rx_byte);
            word0_in = {rx_byte, 8'h00};
            pos_in   = POS_W0_LO;
         end
         POS_W0_LO: begin
            crc_in   = crc8_update(crc_ff, rx_byte);
            word0_in = {word0_ff[15:8], rx_byte};
            pos_in   = POS_W0_CRC;
         end
         POS_W0_CRC: begin
            ok0_in = (crc_ff == rx_byte);
            crc_in = CRC_INIT;
            pos_in = POS_W1_HI;
         end
         POS_W1_HI: begin
            crc_in   = crc8_update(CRC_INIT, rx_byte);
            word1_in = {rx_byte, 8'h00};
            pos_in   = POS_W1_LO;
         end
         POS_W1_LO: begin
            crc_in   = crc8_update(crc_ff, rx_byte);
            word1_in = {word1_ff[15:8], rx_byte};
            pos_in   = POS_W1_CRC;
         end
         POS_W1_CRC: begin
            ok1    = (crc_ff == rx_byte);
            done   = 1'b1;
            crc_in = CRC_INIT;
            pos_in = POS_W0_HI;
         end
         default: begin
            // illegal code: behave as byte zero
            crc_in   = crc8_update(CRC_INIT, rx_byte);
            word0_in = {rx_byte, 8'h00};
            pos_in   = POS_W0_LO;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_W0_HI;
         crc_ff <= CRC_INIT;
         ok0_ff <= 1'b0;
      end else if (fire) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         ok0_ff <= ok0_in;
      end
   end

   // word holds
   always_ff @(posedge clock) begin
      if (fire) begin
         word0_ff <= word0_in;
         word1_ff <= word1_in;
      end
   end

   assign frame.done        = done;
   assign frame.first_word  = word0_ff;
   assign frame.second_word = word1_in;
   assign frame.first_ok    = ok0_ff;
   assign frame.second_ok   = ok1;

endmodule

// ----- src/hmtd_conv.sv -----
// Word ordering, fixed-point conversion and the result register.
module hmtd_conv (
   input  logic                clock,
   input  logic                reset,
   input  logic                humidity_first,
   input  logic                load,
   input  hmtd_pkg::frame_type frame,
   input  logic                rsp_stall,
   output logic                ready,
   output logic                rsp_valid,
   output logic [15:0]         rsp_humidity_raw,
   output logic [15:0]         rsp_temperature_raw,
   output logic                rsp_humidity_crc_ok,
   output logic                rsp_temperature_crc_ok,
   output logic signed [14:0]  rsp_temperature_centi_c,
   output logic [13:0]         rsp_humidity_centi_pct
);
   import hmtd_pkg::*;

   logic [15:0]        hum, tmp;
   logic               hum_ok, tmp_ok;
   logic [30:0]        t_prod;
   logic [29:0]        h_prod;
   logic [14:0]        t_scaled;
   logic               valid_ff, valid_in;
   logic [15:0]        hum_ff, tmp_ff;
   logic               hum_ok_ff, tmp_ok_ff;
   logic signed [14:0] tcent_ff, tcent_in;
   logic [13:0]        hcent_ff, hcent_in;

   // word order select
   always_comb begin
      if (humidity_first) begin
         hum    = frame.first_word;
         hum_ok = frame.first_ok;
         tmp    = frame.second_word;
         tmp_ok = frame.second_ok;
      end else begin
         tmp    = frame.first_word;
         tmp_ok = frame.first_ok;
         hum    = frame.second_word;
         hum_ok = frame.second_ok;
      end
   end

   // scale by constant, keep the integer part (floor)
   assign t_prod   = 31'(tmp) * 31'(TEMP_SCALE);
   assign h_prod   = 30'(hum) * 30'(HUM_SCALE);
   assign t_scaled = t_prod[30:16];
   assign tcent_in = $signed(t_scaled - TEMP_OFFSET);
   assign hcent_in = h_prod[29:16];

   // result register takes a new transaction when empty or draining
   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hum_ff    <= hum;
         tmp_ff    <= tmp;
         hum_ok_ff <= hum_ok;
         tmp_ok_ff <= tmp_ok;
         tcent_ff  <= tcent_in;
         hcent_ff  <= hcent_in;
      end
   end

   assign rsp_valid               = valid_ff;
   assign rsp_humidity_raw        = hum_ff;
   assign rsp_temperature_raw     = tmp_ff;
   assign rsp_humidity_crc_ok     = hum_ok_ff;
   assign rsp_temperature_crc_ok  = tmp_ok_ff;
   assign rsp_temperature_centi_c = tcent_ff;
   assign rsp_humidity_centi_pct  = hcent_ff;

endmodule

// ----- src/humidity_temp_frame_decoder_top.sv -----
// Top level of the humidity/temperature reply frame decoder.
//
//   Channel  Direction  Handshake            Transaction
//   req      in         req_valid/req_stall  one reply byte plus start flag
//   rsp      out        rsp_valid/rsp_stall  decoded words, CRC flags, converted values
//   csr      in         APB psel/penable     humidity_first register at address 0
//
// One byte is accepted per cycle unless a stalled result holds the flow; a byte waits in the input register,
// and the sixth byte of a reply goes from there straight into the result register.
// The CRC-8 update and the two constant multipliers are combinational.
// Synchronous reset clears the byte position, running CRC and both valid flags.
// A stalled result holds; one further byte is still taken into the input register.
module humidity_temp_frame_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   input  logic                            req_frame_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [15:0]                     rsp_humidity_raw,
   output logic [15:0]                     rsp_temperature_raw,
   output logic                            rsp_humidity_crc_ok,
   output logic                            rsp_temperature_crc_ok,
   output logic signed [14:0]              rsp_temperature_centi_c,
   output logic [13:0]                     rsp_humidity_centi_pct,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hmtd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import hmtd_pkg::*;

   logic      in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic      in_start_ff;
   logic      accept;
   logic      advance;
   logic      fire;
   logic      hum_first_ff;
   frame_type frame;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_HUMIDITY_FIRST) ? {31'd0, hum_first_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hum_first_ff <= HUMIDITY_FIRST_RESET;
      end else if (psel && penable && pwrite && pready && paddr == ADDR_HUMIDITY_FIRST) begin
         hum_first_ff <= pwdata[0];
      end
   end

   // input register
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign fire        = in_valid_ff && advance;
   assign in_valid_in = accept ? 1'b1 : (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
   end

   hmtd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .frame       (frame)
   );

   hmtd_conv u_conv (
      .clock                   (clock),
      .reset                   (reset),
      .humidity_first          (hum_first_ff),
      .load                    (fire && frame.done),
      .frame                   (frame),
      .rsp_stall               (rsp_stall),
      .ready                   (advance),
      .rsp_valid               (rsp_valid),
      .rsp_humidity_raw        (rsp_humidity_raw),
      .rsp_temperature_raw     (rsp_temperature_raw),
      .rsp_humidity_crc_ok     (rsp_humidity_crc_ok),
      .rsp_temperature_crc_ok  (rsp_temperature_crc_ok),
      .rsp_temperature_centi_c (rsp_temperature_centi_c),
      .rsp_humidity_centi_pct  (rsp_humidity_centi_pct)
   );

`ifndef SYNTHESIS
   // a completed reply always lands in the result register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      fire && frame.done |=> rsp_valid)
      else $error("completed reply did not produce a result");

   // a new result only appears after the last byte of a reply
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(fire && frame.done))
      else $error("result appeared without a completed reply");

   // converted values stay inside their ranges
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature_centi_c >= -15'sd4500
                 && rsp_temperature_centi_c <= 15'sd12999
                 && rsp_humidity_centi_pct <= 14'd9999)
      else $error("converted value out of range");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the humidity/temperature reply frame decoder.
module tb_top;
   import hmtd_pkg::*;

   localparam int            CLOCK_HALF      = 6;
   localparam int            BYTES_PER_PHASE = 445;
   localparam int            STALL_LIMIT     = 1000;
   localparam int            SETTLE_CYCLES   = 4;
   localparam logic [7:0]    CRC8_SEED       = 8'hFF;
   localparam logic [7:0]    CRC8_POLY       = 8'h31;

   // Byte positions inside one reply
   localparam logic [2:0] AT_WORD0_HI  = 3'd0;
   localparam logic [2:0] AT_WORD0_LO  = 3'd1;
   localparam logic [2:0] AT_WORD0_CRC = 3'd2;
   localparam logic [2:0] AT_WORD1_HI  = 3'd3;
   localparam logic [2:0] AT_WORD1_LO  = 3'd4;
   localparam logic [2:0] AT_WORD1_CRC = 3'd5;

   // One decoded reading as it leaves the block
   typedef struct packed {
      logic [15:0]        humidity_raw;
      logic [15:0]        temperature_raw;
      logic               humidity_crc_ok;
      logic               temperature_crc_ok;
      logic signed [14:0] temperature_centi_c;
      logic [13:0]        humidity_centi_pct;
   } reading_type;

   // Directed stimulus row; a typed reading replaces the computed one
   typedef struct packed {
      logic [7:0]  rx_byte;
      logic        frame_start;
      logic        has_typed;
      reading_type typed;
   } directed_row_type;

   localparam reading_type NO_READING = '0;
   localparam int          N_DIRECTED = 24;

   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // zero humidity, full-scale temperature, both CRCs good
      '{8'h00, 1'b1, 1'b0, NO_READING},
      '{8'h00, 1'b0, 1'b0, NO_READING},
      '{8'h81, 1'b0, 1'b0, NO_READING},
      '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hAC, 1'b0, 1'b1, '{16'hFFFF & 16'h0000, 16'hFFFF, 1'b1, 1'b1, 15'sd12999, 14'd0}},
      // no start flag: position wraps; second CRC is bad
      '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hAC, 1'b0, 1'b0, NO_READING},
      '{8'h00, 1'b0, 1'b0, NO_READING},
      '{8'h00, 1'b0, 1'b0, NO_READING},
      '{8'h7E, 1'b0, 1'b1, '{16'hFFFF, 16'h0000, 1'b1, 1'b0, -15'sd4500, 14'd9999}},
      // start flag in the middle of a reply restarts it
      '{8'hBE, 1'b1, 1'b0, NO_READING},
      '{8'hEF, 1'b0, 1'b0, NO_READING},
      '{8'h92, 1'b0, 1'b0, NO_READING},
      '{8'hBE, 1'b1, 1'b0, NO_READING},
      '{8'hEF, 1'b0, 1'b0, NO_READING},
      '{8'h92, 1'b0, 1'b0, NO_READING},
      '{8'h12, 1'b0, 1'b0, NO_READING},
      '{8'h34, 1'b0, 1'b0, NO_READING},
      '{8'h5A, 1'b0, 1'b0, NO_READING},
      // partial reply left hanging before the first register write
      '{8'hA5, 1'b1, 1'b0, NO_READING},
      '{8'h5A, 1'b0, 1'b0, NO_READING},
      '{8'h00, 1'b0, 1'b0, NO_READING}
   };

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_rx_byte     = 8'h00;
   logic                   req_frame_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic [15:0]            rsp_humidity_raw;
   logic [15:0]            rsp_temperature_raw;
   logic                   rsp_humidity_crc_ok;
   logic                   rsp_temperature_crc_ok;
   logic signed [14:0]     rsp_temperature_centi_c;
   logic [13:0]            rsp_humidity_centi_pct;
   logic                   psel            = 1'b0;
   logic                   penable         = 1'b0;
   logic                   pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr           = '0;
   logic [31:0]            pwdata          = '0;
   logic [31:0]            prdata;
   logic                   pready;

   // Decoder state mirrored by the predictor
   logic [2:0]             frame_pos;
   logic [7:0]             frame_crc;
   logic [15:0]            word0_hold;
   logic [15:0]            word1_hold;
   logic                   word0_ok;
   logic                   humidity_first;

   reading_type            pending_readings [$];
   int                     failures       = 0;
   int                     bytes_sent     = 0;
   int                     readings_seen  = 0;
   int                     sender_idle_pct   = 26;
   int                     receiver_stall_pct = 49;
   int                     quiet_cycles   = 0;

   humidity_temp_frame_decoder_top i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_rx_byte             (req_rx_byte),
      .req_frame_start         (req_frame_start),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_humidity_raw        (rsp_humidity_raw),
      .rsp_temperature_raw     (rsp_temperature_raw),
      .rsp_humidity_crc_ok     (rsp_humidity_crc_ok),
      .rsp_temperature_crc_ok  (rsp_temperature_crc_ok),
      .rsp_temperature_centi_c (rsp_temperature_centi_c),
      .rsp_humidity_centi_pct  (rsp_humidity_centi_pct),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   always #CLOCK_HALF clock = ~clock;

   // CRC-8 one bit at a time, MSB first
   function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ data[i];
         r  = {r[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [7:0] word_crc(input logic [15:0] w);
      return crc8_shift(crc8_shift(CRC8_SEED, w[15:8]), w[7:0]);
   endfunction

   // Advance the mirrored decoder by one byte; a reading comes out on the last byte
   task automatic decode_byte(input logic [7:0] b, input logic s,
                              output logic produced, output reading_type r);
      logic [2:0]  p;
      logic        word1_ok;
      logic [15:0] hum_w;
      logic [15:0] tmp_w;
      logic [31:0] tmp_prod;
      logic [31:0] hum_prod;
      p        = (s || frame_pos > AT_WORD1_CRC) ? AT_WORD0_HI : frame_pos;
      produced = 1'b0;
      r        = NO_READING;
      unique case (p)
         AT_WORD0_HI: begin
            frame_crc  = crc8_shift(CRC8_SEED, b);
            word0_hold = {b, 8'h00};
            frame_pos  = AT_WORD0_LO;
         end
         AT_WORD0_LO: begin
            frame_crc       = crc8_shift(frame_crc, b);
            word0_hold[7:0] = b;
            frame_pos       = AT_WORD0_CRC;
         end
         AT_WORD0_CRC: begin
            word0_ok  = (frame_crc == b);
            frame_crc = CRC8_SEED;
            frame_pos = AT_WORD1_HI;
         end
         AT_WORD1_HI: begin
            frame_crc  = crc8_shift(CRC8_SEED, b);
            word1_hold = {b, 8'h00};
            frame_pos  = AT_WORD1_LO;
         end
         AT_WORD1_LO: begin
            frame_crc       = crc8_shift(frame_crc, b);
            word1_hold[7:0] = b;
            frame_pos       = AT_WORD1_CRC;
         end
         default: begin
            word1_ok = (frame_crc == b);
            if (humidity_first) begin
               hum_w                = word0_hold;
               tmp_w                = word1_hold;
               r.humidity_crc_ok    = word0_ok;
               r.temperature_crc_ok = word1_ok;
            end else begin
               tmp_w                = word0_hold;
               hum_w                = word1_hold;
               r.temperature_crc_ok = word0_ok;
               r.humidity_crc_ok    = word1_ok;
            end
            // floor(scale*raw/2^16), temperature shifted down by 45 degrees
            tmp_prod              = 32'd17500 * {16'h0000, tmp_w};
            hum_prod              = 32'd10000 * {16'h0000, hum_w};
            r.humidity_raw        = hum_w;
            r.temperature_raw     = tmp_w;
            r.temperature_centi_c = tmp_prod[30:16] - 15'd4500;
            r.humidity_centi_pct  = hum_prod[29:16];
            frame_crc             = CRC8_SEED;
            frame_pos             = AT_WORD0_HI;
            produced              = 1'b1;
         end
      endcase
   endtask

   // Offer one byte, wait for the transaction, then predict
   task automatic send_byte(input logic [7:0] b, input logic s,
                            input logic use_typed, input reading_type typed);
      logic        produced;
      reading_type r;
      // idle cycle by cycle at the sender's rate
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= s;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      decode_byte(b, s, produced, r);
      if (produced) pending_readings.push_back(use_typed ? typed : r);
   endtask

   // Stop sending and let every expected reading and any trailing byte drain
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic read_order(input logic [31:0] expected_v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_HUMIDITY_FIRST;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== expected_v) begin
         $error("humidity_first readback: expected %0h, actual %0h", expected_v, prdata);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write the word order with junk in the unused bits, then read it back
   task automatic set_order(input logic order);
      logic [31:0] value;
      value    = $urandom();
      value[0] = order;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_HUMIDITY_FIRST;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      humidity_first = order;
      @(posedge clock);
      read_order({31'd0, order});
   endtask

   function automatic logic [15:0] pick_word();
      unique case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [7:0] pick_crc(input logic [15:0] w);
      logic [7:0] c;
      c = word_crc(w);
      if ($urandom_range(99) < 15) c = c ^ 8'($urandom_range(1, 255));
      return c;
   endfunction

   task automatic check_field(input string name, input int expected_v, input int actual_v);
      if (expected_v != actual_v) begin
         $error("%s: expected %0d, actual %0d", name, expected_v, actual_v);
         failures++;
      end
   endtask

   // Receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Result checker and watchdog
   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         readings_seen++;
         if (pending_readings.size() == 0) begin
            $error("reading arrived with none expected");
            failures++;
         end else begin
            e = pending_readings.pop_front();
            check_field("humidity_raw", e.humidity_raw, rsp_humidity_raw);
            check_field("temperature_raw", e.temperature_raw, rsp_temperature_raw);
            check_field("humidity_crc_ok", e.humidity_crc_ok, rsp_humidity_crc_ok);
            check_field("temperature_crc_ok", e.temperature_crc_ok, rsp_temperature_crc_ok);
            check_field("temperature_centi_c", $signed(e.temperature_centi_c),
                        $signed(rsp_temperature_centi_c));
            check_field("humidity_centi_pct", e.humidity_centi_pct, rsp_humidity_centi_pct);
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      logic [15:0] w0;
      logic [15:0] w1;
      logic [7:0]  frame_bytes [6];
      logic        aligned;
      logic        first_start;
      int          roll;
      int          cut;
      int          target;

      frame_pos      = AT_WORD0_HI;
      frame_crc      = CRC8_SEED;
      word0_hold     = '0;
      word1_hold     = '0;
      word0_ok       = 1'b0;
      humidity_first = HUMIDITY_FIRST_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_order({31'd0, HUMIDITY_FIRST_RESET});

      // Directed rows in reset order
      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].frame_start,
                   DIRECTED_ROWS[i].has_typed, DIRECTED_ROWS[i].typed);
      end

      // Random phases: idle profile and word order change together
      for (int phase = 0; phase < 3; phase++) begin
         drain_block();
         sender_idle_pct    = (phase == 0) ? 26 : (phase == 1) ? 49 : 0;
         receiver_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 26 : 0;
         set_order(phase != 1 ? 1'b0 : 1'b1);
         aligned = 1'b0;
         target  = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < target) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               // noise: stray bytes with a random start flag
               repeat ($urandom_range(1, 3)) begin
                  send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0),
                            1'b0, NO_READING);
               end
               aligned = 1'b0;
            end else begin
               w0 = pick_word();
               w1 = pick_word();
               frame_bytes[0] = w0[15:8];
               frame_bytes[1] = w0[7:0];
               frame_bytes[2] = pick_crc(w0);
               frame_bytes[3] = w1[15:8];
               frame_bytes[4] = w1[7:0];
               frame_bytes[5] = pick_crc(w1);
               // some replies are cut short and restarted by the next one
               cut         = (roll < 13) ? $urandom_range(1, 5) : 6;
               first_start = aligned ? 1'($urandom_range(1)) : 1'b1;
               for (int k = 0; k < cut; k++) begin
                  send_byte(frame_bytes[k], (k == 0) ? first_start : 1'b0, 1'b0, NO_READING);
               end
               aligned = (cut == 6);
            end
         end
      end

      drain_block();
      repeat (8) @(posedge clock);
      if (pending_readings.size() != 0) begin
         $error("%0d readings never arrived", pending_readings.size());
         failures++;
      end
      $display("summary: %0d bytes sent, %0d readings checked", bytes_sent, readings_seen);
      $display("summary: both word orders, CRC errors, restarts, wraps, idling on both sides");
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- humidity_temp_frame_decoder_top.f -----
src/hmtd_pkg.sv
src/hmtd_frame.sv
src/hmtd_conv.sv
src/humidity_temp_frame_decoder_top.sv
verif/tb_top.sv
